// File: sv/dpts_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the dynamic priority task scheduler.
// Used by the controller, the datapath and the top level; no dependencies.
package dpts_pkg;

  localparam int TASK_SLOTS_DEF = 8;

  localparam logic [7:0] RUN_PENALTY_RST = 8'd3;
  localparam logic [7:0] WAIT_BONUS_RST  = 8'd1;

  // Input function codes.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Result status codes.
  localparam logic [2:0] STAT_LOADED   = 3'd0;
  localparam logic [2:0] STAT_REJECTED = 3'd1;
  localparam logic [2:0] STAT_RAN      = 3'd2;
  localparam logic [2:0] STAT_IDLE     = 3'd3;
  localparam logic [2:0] STAT_ALL_DONE = 3'd4;

  // Outcome codes of the task that ran.
  localparam logic [1:0] OUT_REQUEUED = 2'd0;
  localparam logic [1:0] OUT_BLOCKED  = 2'd1;
  localparam logic [1:0] OUT_FINISHED = 2'd2;

  // Slot states.
  localparam logic [1:0] TS_FREE    = 2'd0;
  localparam logic [1:0] TS_READY   = 2'd1;
  localparam logic [1:0] TS_BLOCKED = 2'd2;
  localparam logic [1:0] TS_DONE    = 2'd3;

  // Commands from the controller to the datapath.
  localparam logic [3:0] CMD_NONE      = 4'd0;
  localparam logic [3:0] CMD_LOAD      = 4'd1;
  localparam logic [3:0] CMD_EMPTY     = 4'd2;
  localparam logic [3:0] CMD_TICK_IDLE = 4'd3;
  localparam logic [3:0] CMD_TICK_RUN  = 4'd4;
  localparam logic [3:0] CMD_FIND      = 4'd5;
  localparam logic [3:0] CMD_RUN       = 4'd6;
  localparam logic [3:0] CMD_COUNT     = 4'd7;
  localparam logic [3:0] CMD_FINISH    = 4'd8;

  // Register byte addresses.
  localparam logic [2:0] ADDR_RUN_PENALTY = 3'd0;
  localparam logic [2:0] ADDR_WAIT_BONUS  = 3'd4;

  typedef struct packed {
    logic       func;
    logic [2:0] slot;
    logic [7:0] start_priority;
    logic [7:0] run_length;
    logic [7:0] block_after;
    logic [7:0] block_length;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  running_slot;
    logic [7:0]  running_priority;
    logic [1:0]  running_outcome;
    logic [3:0]  ready_count;
    logic [3:0]  blocked_count;
    logic [15:0] tick_number;
  } out_t;

  typedef struct packed {
    logic ready_empty;
    logic blocked_empty;
    logic find_done;
    logic count_done;
  } dp_status_t;

endpackage

// File: sv/dpts_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the task scheduler.
// Depends on dpts_pkg; drives command codes into dpts_datapath.
module dpts_ctrl
  import dpts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       func,
  input  dp_status_t dp_status,
  output logic [3:0] cmd,
  output logic       busy
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FIND  = 2'd1;
  localparam logic [1:0] S_COUNT = 2'd2;

  logic [1:0] state, state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (func == FUNC_LOAD) begin
            cmd = CMD_LOAD;
          end else if (dp_status.ready_empty && dp_status.blocked_empty) begin
            cmd = CMD_EMPTY;
          end else if (dp_status.ready_empty) begin
            cmd        = CMD_TICK_IDLE;
            state_next = S_COUNT;
          end else begin
            cmd        = CMD_TICK_RUN;
            state_next = S_FIND;
          end
        end
      end
      S_FIND: begin
        if (dp_status.find_done) begin
          cmd        = CMD_RUN;
          state_next = S_COUNT;
        end else begin
          cmd = CMD_FIND;
        end
      end
      S_COUNT: begin
        if (dp_status.count_done) begin
          cmd        = CMD_FINISH;
          state_next = S_IDLE;
        end else begin
          cmd = CMD_COUNT;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: sv/dpts_datapath.sv
`timescale 1ns / 1ps
// Task table, ready queue, blocked list and result register of the scheduler.
// Depends on dpts_pkg; sequenced by dpts_ctrl through command codes.
module dpts_datapath
  import dpts_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [3:0] cmd,
  input  in_t        item,
  input  logic [7:0] run_penalty,
  input  logic [7:0] wait_bonus,
  output dp_status_t dp_status,
  output logic       done,
  output out_t       result
);

  localparam int IW = $clog2(TASK_SLOTS);
  localparam int CW = $clog2(TASK_SLOTS + 1);

  logic [7:0]    prio   [TASK_SLOTS];
  logic [7:0]    exec   [TASK_SLOTS];
  logic [7:0]    remain [TASK_SLOTS];
  logic [7:0]    bpoint [TASK_SLOTS];
  logic [7:0]    bleft  [TASK_SLOTS];
  logic [1:0]    tstat  [TASK_SLOTS];
  logic [IW-1:0] rorder [TASK_SLOTS];
  logic [IW-1:0] border [TASK_SLOTS];

  logic [CW-1:0] rsize, bsize;
  logic [15:0]   tick;
  logic [CW-1:0] scan, best, rd, wr, cend;
  logic [7:0]    bestp;
  logic [IW-1:0] cur_slot;
  logic          idle_tick;

  logic [IW-1:0] ld_slot, run_slot, cnt_slot;
  logic          ld_ok;
  logic [7:0]    scan_p, cnt_left;
  logic          fin_block, fin_done_task;
  logic [CW-1:0] rsize_fin, bsize_fin;
  logic [7:0]    pen_prio;
  logic [8:0]    bonus_sum [TASK_SLOTS];
  logic          done_next;
  out_t          result_next;

  assign ld_slot  = IW'(item.slot);
  assign ld_ok    = (32'(item.slot) < 32'(TASK_SLOTS)) &&
                    (tstat[ld_slot] != TS_READY) && (tstat[ld_slot] != TS_BLOCKED);
  assign run_slot = rorder[best[IW-1:0]];
  assign scan_p   = prio[rorder[scan[IW-1:0]]];
  assign cnt_slot = border[rd[IW-1:0]];
  assign cnt_left = (bleft[cnt_slot] != 8'd0) ? bleft[cnt_slot] - 8'd1 : 8'd0;
  assign pen_prio = (prio[run_slot] > run_penalty) ? prio[run_slot] - run_penalty : 8'd0;

  assign fin_done_task = (remain[cur_slot] == 8'd0);
  assign fin_block     = !fin_done_task && (bpoint[cur_slot] != 8'd0) &&
                         (bpoint[cur_slot] == exec[cur_slot]);

  always_comb begin
    for (int k = 0; k < TASK_SLOTS; k++) begin
      bonus_sum[k] = {1'b0, prio[k]} + {1'b0, wait_bonus};
    end
  end

  always_comb begin
    rsize_fin = rsize;
    bsize_fin = wr;
    if (!idle_tick) begin
      if (fin_block && (wr < CW'(TASK_SLOTS))) begin
        bsize_fin = wr + CW'(1);
      end else if (!fin_done_task && !fin_block && (rsize < CW'(TASK_SLOTS))) begin
        rsize_fin = rsize + CW'(1);
      end
    end
  end

  // The result beat is assembled here and registered below.
  always_comb begin
    done_next   = 1'b0;
    result_next = result;
    case (cmd)
      CMD_LOAD: begin
        done_next                 = 1'b1;
        result_next               = '0;
        result_next.ready_count   = 4'(rsize);
        result_next.blocked_count = 4'(bsize);
        result_next.tick_number   = tick;
        if (ld_ok) begin
          result_next.status = STAT_LOADED;
          if (rsize < CW'(TASK_SLOTS)) begin
            result_next.ready_count = 4'(rsize + CW'(1));
          end
        end else begin
          result_next.status = STAT_REJECTED;
        end
      end
      CMD_EMPTY: begin
        done_next               = 1'b1;
        result_next             = '0;
        result_next.status      = STAT_ALL_DONE;
        result_next.tick_number = tick;
      end
      CMD_FINISH: begin
        done_next                 = 1'b1;
        result_next               = '0;
        result_next.ready_count   = 4'(rsize_fin);
        result_next.blocked_count = 4'(bsize_fin);
        result_next.tick_number   = tick;
        if (idle_tick) begin
          result_next.status = STAT_IDLE;
        end else begin
          result_next.status           = STAT_RAN;
          result_next.running_slot     = 3'(cur_slot);
          result_next.running_priority = prio[cur_slot];
          if (fin_done_task) begin
            result_next.running_outcome = OUT_FINISHED;
          end else if (fin_block) begin
            result_next.running_outcome = OUT_BLOCKED;
          end else begin
            result_next.running_outcome = OUT_REQUEUED;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign dp_status.ready_empty   = (rsize == '0);
  assign dp_status.blocked_empty = (bsize == '0);
  assign dp_status.find_done     = (scan >= rsize);
  assign dp_status.count_done    = (rd >= cend);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TASK_SLOTS; k++) begin
        prio[k]   <= '0;
        exec[k]   <= '0;
        remain[k] <= '0;
        bpoint[k] <= '0;
        bleft[k]  <= '0;
        tstat[k]  <= TS_FREE;
      end
      rsize  <= '0;
      bsize  <= '0;
      tick   <= '0;
      done   <= 1'b0;
      result <= '0;
    end else begin
      done   <= done_next;
      result <= result_next;
      case (cmd)
        CMD_LOAD: begin
          if (ld_ok) begin
            prio[ld_slot]   <= item.start_priority;
            exec[ld_slot]   <= '0;
            remain[ld_slot] <= (item.run_length != 8'd0) ? item.run_length : 8'd1;
            bpoint[ld_slot] <= item.block_after;
            bleft[ld_slot]  <= (item.block_length != 8'd0) ? item.block_length : 8'd1;
            tstat[ld_slot]  <= TS_READY;
            if (rsize < CW'(TASK_SLOTS)) begin
              rorder[rsize[IW-1:0]] <= ld_slot;
              rsize                 <= rsize + CW'(1);
            end
          end
        end
        CMD_TICK_IDLE: begin
          tick      <= tick + 16'd1;
          idle_tick <= 1'b1;
          rd        <= '0;
          wr        <= '0;
          cend      <= bsize;
        end
        CMD_TICK_RUN: begin
          tick      <= tick + 16'd1;
          idle_tick <= 1'b0;
          scan      <= CW'(1);
          best      <= '0;
          bestp     <= prio[rorder[0]];
        end
        CMD_FIND: begin
          if (scan_p > bestp) begin
            best  <= scan;
            bestp <= scan_p;
          end
          scan <= scan + CW'(1);
        end
        CMD_RUN: begin
          // Close the gap left by the chosen task, then age the table.
          for (int k = 0; k < TASK_SLOTS - 1; k++) begin
            if (CW'(k) >= best) begin
              rorder[k] <= rorder[k+1];
            end
          end
          rsize    <= rsize - CW'(1);
          cur_slot <= run_slot;
          for (int k = 0; k < TASK_SLOTS; k++) begin
            if (IW'(k) == run_slot) begin
              prio[k] <= pen_prio;
              if (exec[k] != 8'hFF) exec[k] <= exec[k] + 8'd1;
              if (remain[k] != 8'd0) remain[k] <= remain[k] - 8'd1;
            end else if (tstat[k] == TS_READY) begin
              prio[k] <= bonus_sum[k][8] ? 8'hFF : bonus_sum[k][7:0];
            end
          end
          rd   <= '0;
          wr   <= '0;
          cend <= bsize;
        end
        CMD_COUNT: begin
          bleft[cnt_slot] <= cnt_left;
          if (cnt_left == 8'd0) begin
            tstat[cnt_slot] <= TS_READY;
            if (rsize < CW'(TASK_SLOTS)) begin
              rorder[rsize[IW-1:0]] <= cnt_slot;
              rsize                 <= rsize + CW'(1);
            end
          end else begin
            border[wr[IW-1:0]] <= cnt_slot;
            wr                 <= wr + CW'(1);
          end
          rd <= rd + CW'(1);
        end
        CMD_FINISH: begin
          rsize <= rsize_fin;
          bsize <= bsize_fin;
          if (!idle_tick) begin
            if (fin_done_task) begin
              tstat[cur_slot] <= TS_DONE;
            end else if (fin_block) begin
              tstat[cur_slot] <= TS_BLOCKED;
              if (wr < CW'(TASK_SLOTS)) begin
                border[wr[IW-1:0]] <= cur_slot;
              end
            end else begin
              if (rsize < CW'(TASK_SLOTS)) begin
                rorder[rsize[IW-1:0]] <= cur_slot;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: sv/dynamic_priority_task_scheduler_top.sv
`timescale 1ns / 1ps
// A load beat fills a task slot. A tick beat scans the ready queue, if it holds
// any task, one entry a cycle for the winner, and then the blocked list, one
// entry a cycle, for the timer count-down; the two scans cover at most
// TASK_SLOTS entries, since a slot sits in one list at most. A tick with nothing
// left to run skips both scans. busy is high while a tick is in work, and start
// is only taken while busy is low. Each result is registered and appears in the
// cycle after its last work cycle, for exactly one cycle under done; the
// receiver cannot stall it and must take it then.
// Depends on dpts_pkg, dpts_ctrl and dpts_datapath.
module dynamic_priority_task_scheduler_top
  import dpts_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_t         item,
  output logic        done,
  output out_t        result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] run_penalty, wait_bonus;
  logic [3:0] cmd;
  dp_status_t dp_status;

  assign pready = 1'b1;

  // Only bit 2 of the address selects a register.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_penalty <= RUN_PENALTY_RST;
      wait_bonus  <= WAIT_BONUS_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == ADDR_WAIT_BONUS[2]) begin
        wait_bonus <= pwdata[7:0];
      end else begin
        run_penalty <= pwdata[7:0];
      end
    end
  end

  assign prdata = (paddr[2] == ADDR_WAIT_BONUS[2]) ? {24'd0, wait_bonus}
                                                   : {24'd0, run_penalty};

  dpts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .func      (item.func),
    .dp_status (dp_status),
    .cmd       (cmd),
    .busy      (busy)
  );

  dpts_datapath #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .item        (item),
    .run_penalty (run_penalty),
    .wait_bonus  (wait_bonus),
    .dp_status   (dp_status),
    .done        (done),
    .result      (result)
  );

endmodule
